// ===== rtl/salru_pkg.sv =====
// ----------------------------------------------------------------------------
// salru_pkg
// shared codes and types of the lru tag array
// ----------------------------------------------------------------------------
package salru_pkg;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [3:0] LINE_OFFSET_RESET = 4'd6;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

endpackage

// ===== rtl/salru_tag_ram.sv =====
// ----------------------------------------------------------------------------
// salru_tag_ram
// single-port tag memory with registered read data
// ----------------------------------------------------------------------------
module salru_tag_ram #(
    parameter int AW = 9,
    parameter int DW = 42
) (
    input  logic                clk,
    input  salru_pkg::ram_ctl_t ctl,
    input  logic [AW-1:0]       addr,
    input  logic [DW-1:0]       wdata,
    output logic [DW-1:0]       rdata
);
    import salru_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/set_assoc_lru_tag_array.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_array
// set-associative tag array with true lru replacement
// ----------------------------------------------------------------------------
// requests enter on the s_ channel: tuser[0] is the mode (lookup or insert),
// tdata the byte address. each request gives one response on the m_ channel
// with the hit flag in tdata[0]. cfg_we/cfg_wdata set the line offset.
// one request is worked on at a time; s_tready is high only while idle.
// an insert goes from ST_META through ST_DECIDE to ST_DONE, then to idle.
// a lookup walks the set in recency order through one tag comparator that
// reads one way at a time from the single-port tag ram (ST_TREQ, ST_TCMP):
// a miss ends after the last valid way, a hit goes on to ST_WRITE to promote it.
// the response sits in an output register: a new request is taken while it
// waits, and a finished request holds in its last state until m_tready frees
// that register.
// after reset the recency and fill state of every set is written back to its
// initial value, one set per cycle, so the block takes no request until
// all sets are cleared; the line offset returns to 6 and all ways read as empty.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_array #(
    parameter int SETS      = 64,
    parameter int WAYS      = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((ADDR_BITS+7)/8)*8-1:0]    s_tdata,   // address
    input  logic [0:0]                        s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // hit
    input  logic                              cfg_we,
    input  logic [3:0]                        cfg_wdata
);
    import salru_pkg::*;

    localparam int IDX_BITS = $clog2(SETS + 1) - 1;
    localparam int SW       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FCW      = $clog2(WAYS + 1);
    localparam int TW       = ADDR_BITS - IDX_BITS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_META   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_TREQ   = 3'd4;
    localparam logic [2:0] ST_TCMP   = 3'd5;
    localparam logic [2:0] ST_WRITE  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [SW-1:0]               clr_idx_reg, clr_idx_next;
    logic [FCW-1:0]              rank_reg, rank_next;
    logic                        hit_res_reg, hit_res_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_hit_reg;
    logic [3:0]                  off_reg;

    logic [ADDR_BITS-1:0]        addr_reg;
    logic                        mode_reg;
    logic [SW-1:0]               set_reg;
    logic [TW-1:0]               tag_reg;
    logic [WAYS-1:0][WB-1:0]     order_rd_reg;
    logic [FCW-1:0]              fill_rd_reg;

    logic [WAYS-1:0][WB-1:0]     order_mem [SETS];
    logic [FCW-1:0]              fill_mem [SETS];

    logic [ADDR_BITS-1:0]        shifted;
    logic [ADDR_BITS-1:0]        tag_full;
    logic [SW-1:0]               set_calc;
    logic [TW-1:0]               tag_calc;

    logic                        set_full;
    logic [FCW-1:0]              ins_rank;
    logic [FCW-1:0]              sel_rank;
    logic [WB-1:0]               cur_way;
    logic [WAYS-1:0][WB-1:0]     order_prom;
    logic [WAYS-1:0][WB-1:0]     order_init;
    logic                        meta_we;
    logic [SW-1:0]               meta_waddr;
    logic [WAYS-1:0][WB-1:0]     meta_worder;
    logic [FCW-1:0]              meta_wfill;

    ram_ctl_t                    tag_ctl;
    logic [TW-1:0]               tag_rdata;
    logic                        out_load;
    logic                        tag_match;

    // set and tag from the captured address
    always_comb
    begin
        shifted  = addr_reg >> off_reg;
        tag_full = shifted >> IDX_BITS;
        set_calc = shifted[SW-1:0] & SW'(SETS - 1);
        tag_calc = tag_full[TW-1:0];
    end

    // valid ways always sit at ranks below the fill count
    always_comb
    begin
        set_full = (fill_rd_reg == FCW'(WAYS));
        ins_rank = set_full ? FCW'(WAYS - 1) : fill_rd_reg;
        sel_rank = (state_reg == ST_DECIDE) ? ins_rank : rank_reg;
        cur_way  = order_rd_reg[sel_rank[WB-1:0]];
    end

    // move the selected rank to the front
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            order_init[i] = WB'(i);
            if (i == 0)
            begin
                order_prom[i] = order_rd_reg[sel_rank[WB-1:0]];
            end
            else if (FCW'(i) <= sel_rank)
            begin
                order_prom[i] = order_rd_reg[i-1];
            end
            else
            begin
                order_prom[i] = order_rd_reg[i];
            end
        end
    end

    always_comb
    begin
        meta_we     = 1'b0;
        meta_waddr  = set_reg;
        meta_worder = order_prom;
        meta_wfill  = fill_rd_reg;
        if (state_reg == ST_CLEAR)
        begin
            meta_we     = 1'b1;
            meta_waddr  = clr_idx_reg;
            meta_worder = order_init;
            meta_wfill  = '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            meta_we = 1'b1;
        end
        else if (state_reg == ST_DECIDE && mode_reg == OP_INSERT)
        begin
            meta_we = 1'b1;
            if (!set_full)
            begin
                meta_wfill = fill_rd_reg + FCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            order_mem[meta_waddr] <= meta_worder;
            fill_mem[meta_waddr]  <= meta_wfill;
        end
        if (state_reg == ST_META)
        begin
            order_rd_reg <= order_mem[set_calc];
            fill_rd_reg  <= fill_mem[set_calc];
        end
    end

    always_comb
    begin
        tag_ctl.rd_en = (state_reg == ST_TREQ) && (rank_reg != fill_rd_reg);
        tag_ctl.wr_en = (state_reg == ST_DECIDE) && (mode_reg == OP_INSERT);
    end

    salru_tag_ram #(
        .AW (SW + WB),
        .DW (TW)
    ) u_tag_ram (
        .clk   (clk),
        .ctl   (tag_ctl),
        .addr  ({set_reg, cur_way}),
        .wdata (tag_reg),
        .rdata (tag_rdata)
    );

    assign tag_match = (tag_rdata == tag_reg);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        rank_next    = rank_reg;
        hit_res_next = hit_res_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SW'(1);
                if (clr_idx_reg == SW'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                rank_next    = '0;
                hit_res_next = 1'b0;
                if (mode_reg == OP_INSERT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TREQ;
                end
            end
            ST_TREQ:
            begin
                if (rank_reg == fill_rd_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TCMP;
                end
            end
            ST_TCMP:
            begin
                if (tag_match)
                begin
                    hit_res_next = 1'b1;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    rank_next  = rank_reg + FCW'(1);
                    state_next = ST_TREQ;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            rank_reg      <= '0;
            hit_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            off_reg       <= LINE_OFFSET_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rank_reg      <= rank_next;
            hit_res_reg   <= hit_res_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                off_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            addr_reg <= s_tdata[ADDR_BITS-1:0];
            mode_reg <= s_tuser[0];
        end
        if (state_reg == ST_META)
        begin
            set_reg <= set_calc;
            tag_reg <= tag_calc;
        end
        if (out_load)
        begin
            out_hit_reg <= hit_res_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_hit_reg};

endmodule
